// File: src/cd_pkg.sv
// Shared types and constants for the circular deque.
// Used by every module of the block but cd_ram; has no dependencies of its own.
package cd_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_t;

  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned CAP_FIELD_W = 11;
  localparam logic        REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic clear;
    logic single;
  } cfg_evt_t;

endpackage

// File: src/circular_deque.sv
// Top level of the circular deque: ties the register port, sequencer and slot RAM.
// Depends on cd_pkg, cd_cfg, cd_core and cd_ram.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_stall  | cmd, value
//   out     | output    | out_valid/out_stall| accepted, front/back valid+value,
//           |           |                    | is_empty, is_full
//   config  | input     | APB psel/penable   | capacity at address 0
//
// Push, query and unknown commands load the result register directly; a pop that
// leaves words behind first reads the new end slot from the RAM and loads the
// result from ST_RESP. One word is in flight at a time; the result register frees
// the input side as soon as the result is taken, or at once when it is empty.
// Reset (synchronous, high) empties the queue and sets capacity to DEPTH; the
// slot RAM is not cleared. Stalling the output holds the result and the input.
module circular_deque #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                cmd,
  input  logic [DATA_WIDTH-1:0]     value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      accepted,
  output logic                      front_valid,
  output logic [DATA_WIDTH-1:0]     front_value,
  output logic                      back_valid,
  output logic [DATA_WIDTH-1:0]     back_value,
  output logic                      is_empty,
  output logic                      is_full
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CAP_W = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]      capacity;
  cd_pkg::cfg_evt_t      evt;
  logic                  mem_we, mem_re;
  logic [PTR_W-1:0]      mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  cd_cfg #(
    .DEPTH (DEPTH),
    .CAP_W (CAP_W)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity),
    .evt      (evt)
  );

  cd_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PTR_W      (PTR_W),
    .CAP_W      (CAP_W)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .capacity    (capacity),
    .evt         (evt),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .accepted    (accepted),
    .front_valid (front_valid),
    .front_value (front_value),
    .back_valid  (back_valid),
    .back_value  (back_value),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  cd_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PTR_W      (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: src/cd_ram.sv
// Slot memory of the circular deque: one write port, one registered read port.
// Depends on nothing.
module cd_ram #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned PTR_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [PTR_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [PTR_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/cd_cfg.sv
// APB-style register port holding the capacity of the circular deque.
// Depends on cd_pkg for the register index and the clear event struct.
module cd_cfg #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned CAP_W = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [CAP_W-1:0]          capacity,
  output cd_pkg::cfg_evt_t          evt
);

  logic                               wr_cap;
  logic [cd_pkg::CAP_FIELD_W-1:0]     raw;
  logic [31:0]                        raw32;
  logic [CAP_W-1:0]                   cap_next;

  assign pready = 1'b1;
  assign wr_cap = psel && penable && pwrite && pready && (paddr[2] == cd_pkg::REG_CAPACITY);
  assign raw    = pwdata[cd_pkg::CAP_FIELD_W-1:0];
  assign raw32  = 32'(raw);

  always_comb begin
    priority if (raw32 == 32'd0) begin
      cap_next = CAP_W'(1);
    end else if (raw32 > 32'(DEPTH)) begin
      cap_next = CAP_W'(DEPTH);
    end else begin
      cap_next = CAP_W'(raw32);
    end
  end

  assign evt.clear  = wr_cap;
  assign evt.single = (cap_next == CAP_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(DEPTH);
    end else if (wr_cap) begin
      capacity <= cap_next;
    end
  end

  assign prdata = (paddr[2] == cd_pkg::REG_CAPACITY) ? 32'(capacity) : 32'd0;

endmodule

// File: src/cd_core.sv
// Command sequencer of the circular deque: ring pointers, fill count, cached
// end words and the result register. Depends on cd_pkg; drives cd_ram.
module cd_core #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned PTR_W      = $clog2(DEPTH),
  parameter int unsigned CAP_W      = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CAP_W-1:0]      capacity,
  input  cd_pkg::cfg_evt_t      evt,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            cmd,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  accepted,
  output logic                  front_valid,
  output logic [DATA_WIDTH-1:0] front_value,
  output logic                  back_valid,
  output logic [DATA_WIDTH-1:0] back_value,
  output logic                  is_empty,
  output logic                  is_full,
  output logic                  mem_we,
  output logic [PTR_W-1:0]      mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [PTR_W-1:0]      mem_raddr,
  input  logic [DATA_WIDTH-1:0] mem_rdata
);

  localparam int unsigned EXT_W = PTR_W + 1;

  cd_pkg::state_t        state, state_next;
  logic [PTR_W-1:0]      front_ptr, front_ptr_next;
  logic [PTR_W-1:0]      back_ptr, back_ptr_next;
  logic [CAP_W-1:0]      count, count_next;
  logic [DATA_WIDTH-1:0] front_word, front_word_next;
  logic [DATA_WIDTH-1:0] back_word, back_word_next;
  logic                  rd_front, rd_front_next;

  logic                  accept, out_free, load;
  logic                  full, empty, ok;
  logic                  ld_ok;
  logic [CAP_W-1:0]      ld_count;
  logic [DATA_WIDTH-1:0] ld_front, ld_back;
  logic                  empty_link;

  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] cap);
    logic [EXT_W-1:0] inc;
    inc = {1'b0, p} + EXT_W'(1);
    return (inc >= EXT_W'(cap)) ? PTR_W'(0) : inc[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] top;
    top = cap - CAP_W'(1);
    return (p == PTR_W'(0)) ? PTR_W'(top) : p - PTR_W'(1);
  endfunction

  assign out_free = !(out_valid && out_stall);
  assign in_stall = (state != cd_pkg::ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = (count >= capacity);
  assign empty    = (count == CAP_W'(0));
  assign mem_wdata = value;

  always_comb begin
    state_next      = state;
    front_ptr_next  = front_ptr;
    back_ptr_next   = back_ptr;
    count_next      = count;
    front_word_next = front_word;
    back_word_next  = back_word;
    rd_front_next   = rd_front;
    ok              = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = front_ptr;
    mem_re          = 1'b0;
    mem_raddr       = front_ptr;
    load            = 1'b0;
    ld_ok           = 1'b0;
    ld_count        = count;
    ld_front        = front_word;
    ld_back         = back_word;

    unique case (state)
      cd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cd_pkg::cmd_t'(cmd))
            cd_pkg::CMD_PUSH_FRONT: begin
              if (!full) begin
                front_ptr_next  = step_down(front_ptr, capacity);
                mem_we          = 1'b1;
                mem_waddr       = front_ptr_next;
                front_word_next = value;
                if (empty) begin
                  back_word_next = value;
                end
                count_next = count + CAP_W'(1);
                ok         = 1'b1;
              end
            end
            cd_pkg::CMD_PUSH_BACK: begin
              if (!full) begin
                back_ptr_next  = step_up(back_ptr, capacity);
                mem_we         = 1'b1;
                mem_waddr      = back_ptr_next;
                back_word_next = value;
                if (empty) begin
                  front_word_next = value;
                end
                count_next = count + CAP_W'(1);
                ok         = 1'b1;
              end
            end
            cd_pkg::CMD_POP_FRONT: begin
              if (!empty) begin
                front_ptr_next = step_up(front_ptr, capacity);
                count_next     = count - CAP_W'(1);
                ok             = 1'b1;
                if (count_next != CAP_W'(0)) begin
                  mem_re        = 1'b1;
                  mem_raddr     = front_ptr_next;
                  rd_front_next = 1'b1;
                end
              end
            end
            cd_pkg::CMD_POP_BACK: begin
              if (!empty) begin
                back_ptr_next = step_down(back_ptr, capacity);
                count_next    = count - CAP_W'(1);
                ok            = 1'b1;
                if (count_next != CAP_W'(0)) begin
                  mem_re        = 1'b1;
                  mem_raddr     = back_ptr_next;
                  rd_front_next = 1'b0;
                end
              end
            end
            cd_pkg::CMD_QUERY: begin
              ok = 1'b1;
            end
            default: begin
              ok = 1'b0;
            end
          endcase
          if (mem_re) begin
            state_next = cd_pkg::ST_RESP;
          end else begin
            load     = 1'b1;
            ld_ok    = ok;
            ld_count = count_next;
            ld_front = front_word_next;
            ld_back  = back_word_next;
          end
        end
      end
      cd_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = cd_pkg::ST_IDLE;
          load       = 1'b1;
          ld_ok      = 1'b1;
          ld_count   = count;
          if (rd_front) begin
            front_word_next = mem_rdata;
          end else begin
            back_word_next = mem_rdata;
          end
          ld_front = front_word_next;
          ld_back  = back_word_next;
        end
      end
      default: begin
        state_next = cd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cd_pkg::ST_IDLE;
      front_ptr <= PTR_W'(1);
      back_ptr  <= PTR_W'(0);
      count     <= CAP_W'(0);
      out_valid <= 1'b0;
    end else if (evt.clear) begin
      front_ptr <= evt.single ? PTR_W'(0) : PTR_W'(1);
      back_ptr  <= PTR_W'(0);
      count     <= CAP_W'(0);
    end else begin
      state     <= state_next;
      front_ptr <= front_ptr_next;
      back_ptr  <= back_ptr_next;
      count     <= count_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_word <= front_word_next;
    back_word  <= back_word_next;
    rd_front   <= rd_front_next;
    if (load) begin
      accepted    <= ld_ok;
      front_valid <= (ld_count != CAP_W'(0));
      back_valid  <= (ld_count != CAP_W'(0));
      front_value <= (ld_count != CAP_W'(0)) ? ld_front : '0;
      back_value  <= (ld_count != CAP_W'(0)) ? ld_back : '0;
      is_empty    <= (ld_count == CAP_W'(0));
      is_full     <= (ld_count >= capacity);
    end
  end

  assign empty_link = (step_up(back_ptr, capacity) == front_ptr);

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= capacity)
    else $error("fill count above capacity");

  a_resp_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == cd_pkg::ST_RESP |-> in_stall && !mem_we)
    else $error("input taken or slot written during read response");

  a_empty_pointers: assert property (@(posedge clk) disable iff (rst)
    count == CAP_W'(0) |-> empty_link)
    else $error("empty queue with front not one past back");

  a_read_only_nonempty: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> state == cd_pkg::ST_RESP && count != CAP_W'(0))
    else $error("slot read without a response pending");

endmodule
